// File: sv/balas_pkg.sv
// Shared types, status codes and saturation helpers for the ballistic arc launch solver.
// No dependencies; every other file of the block but balas_div refers to this package by scoped name.
package balas_pkg;

    localparam int ROOT_W = 32;
    localparam int RAD_W  = 64;

    localparam logic [1:0] MODE_BALLISTIC = 2'd0;
    localparam logic [1:0] MODE_LINEAR    = 2'd1;
    localparam logic [1:0] MODE_INVALID   = 2'd2;

    localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_SOLVED  = 2'd0,
        ST_LINEAR  = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // side data that rides along the first root unit
    typedef struct packed {
        logic signed [31:0] along;
        logic [30:0]        acc;
        t_status            status;
    } t_front_side;

    // side data through the flight time divider
    typedef struct packed {
        logic [30:0]        vu;
        logic [30:0]        hlen;
        logic signed [31:0] along;
        t_status            status;
    } t_tdiv_side;

    // side data through the horizontal speed divider
    typedef struct packed {
        logic [30:0]        vu;
        logic [30:0]        t;
        logic signed [31:0] along;
        t_status            status;
        logic               tzero;
        logic               hlen_nz;
    } t_vdiv_side;

    // side data through the launch speed root
    typedef struct packed {
        logic signed [31:0] pred;
        logic [30:0]        vu;
        t_status            status;
    } t_root_side;

    // clamp a signed value to the signed 32 bit range
    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < 64'shFFFF_FFFF_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // clamp an unsigned value to 0..0x7FFFFFFF
    function automatic logic [30:0] sat_u31(input logic [63:0] x);
        if (x > 64'h0000_0000_7FFF_FFFF) begin
            return U31_MAX;
        end
        return x[30:0];
    endfunction

endpackage

// File: sv/ballistic_arc_launch_solver_top.sv
// Top level of the ballistic arc launch solver: front end, root units, dividers, output stage.
// Depends on balas_pkg, balas_front, balas_sqrt and balas_div.
//
// The solver takes one beat on every clock at which start is high; busy never rises,
// since nothing inside holds work back and the receiver cannot stall. Each result
// appears on o_done in order, after its beat has passed through 7 front
// stages, 32 root stages for the horizontal length and phase speeds, a register and a
// 48 stage divider for the flight time, a register and a 47 stage divider for the
// horizontal speed, 3 product stages, 32 root stages for the launch speed and the
// output register. The pipeline depth is set by the bit-per-stage root and divide units.
module ballistic_arc_launch_solver_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_tip_x,
    input  logic signed [31:0] i_tip_y,
    input  logic signed [31:0] i_tip_z,
    input  logic signed [31:0] i_aim_x,
    input  logic signed [31:0] i_aim_y,
    input  logic signed [31:0] i_aim_z,
    input  logic signed [17:0] i_up_x,
    input  logic signed [17:0] i_up_y,
    input  logic signed [17:0] i_up_z,
    input  logic [30:0]        i_accel,
    input  logic [30:0]        i_height_max,
    input  logic [1:0]         i_mode,
    output logic               o_done,
    output logic signed [31:0] o_prediction,
    output logic [30:0]        o_start_speed,
    output logic [1:0]         o_status
);
    localparam int TNUM_W = 48;
    localparam int VNUM_W = 47;
    localparam int DEN_W  = 31;

    logic                          w_take;
    logic                          f_vld;
    logic [balas_pkg::RAD_W-1:0]   f_rad [3];
    balas_pkg::t_front_side        f_side;

    logic                          s1_vld;
    logic [balas_pkg::ROOT_W-1:0]  s1_root [3];
    logic [$bits(balas_pkg::t_front_side)-1:0] s1_side_v;
    balas_pkg::t_front_side        s1_side;

    logic                          r_p1_vld;
    logic [31:0]                   r_p1_sum;
    logic [30:0]                   r_p1_acc;
    balas_pkg::t_tdiv_side         r_p1_side;

    logic                          dt_vld;
    logic [TNUM_W-1:0]             dt_quo;
    logic [$bits(balas_pkg::t_tdiv_side)-1:0] dt_side_v;
    balas_pkg::t_tdiv_side         dt_side;

    logic                          r_p2_vld;
    logic [VNUM_W-1:0]             r_p2_num;
    balas_pkg::t_vdiv_side         r_p2_side;
    logic [30:0]                   n_p2_t;

    logic                          dv_vld;
    logic [VNUM_W-1:0]             dv_quo;
    logic [$bits(balas_pkg::t_vdiv_side)-1:0] dv_side_v;
    balas_pkg::t_vdiv_side         dv_side;

    logic                          r_p3_vld;
    logic [30:0]                   r_p3_vh, r_p3_vu, r_p3_t;
    logic signed [31:0]            r_p3_along;
    balas_pkg::t_status            r_p3_st;
    logic [30:0]                   n_p3_vh;

    logic                          r_p4_vld;
    logic [61:0]                   r_p4_vh2, r_p4_vu2, r_p4_tvu;
    logic [30:0]                   r_p4_vu;
    logic signed [31:0]            r_p4_along;
    balas_pkg::t_status            r_p4_st;

    logic                          r_p5_vld;
    logic [balas_pkg::RAD_W-1:0]   r_p5_rad [1];
    balas_pkg::t_root_side         r_p5_side;

    logic                          s2_vld;
    logic [balas_pkg::ROOT_W-1:0]  s2_root [1];
    logic [$bits(balas_pkg::t_root_side)-1:0] s2_side_v;
    balas_pkg::t_root_side         s2_side;

    logic                          r_done;
    logic signed [31:0]            r_pred;
    logic [30:0]                   r_speed;
    balas_pkg::t_status            r_status;

    // the pipeline never holds a beat back
    assign busy   = 1'b0;
    assign w_take = start && !busy;

    balas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_take),
        .i_tip_x      (i_tip_x),
        .i_tip_y      (i_tip_y),
        .i_tip_z      (i_tip_z),
        .i_aim_x      (i_aim_x),
        .i_aim_y      (i_aim_y),
        .i_aim_z      (i_aim_z),
        .i_up_x       (i_up_x),
        .i_up_y       (i_up_y),
        .i_up_z       (i_up_z),
        .i_accel      (i_accel),
        .i_height_max (i_height_max),
        .i_mode       (i_mode),
        .o_vld        (f_vld),
        .o_rad        (f_rad),
        .o_side       (f_side)
    );

    // horizontal length, up speed and down speed in three lanes
    balas_sqrt #(
        .LANES  (3),
        .SIDE_W ($bits(balas_pkg::t_front_side))
    ) u_sqrt_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_vld   (s1_vld),
        .o_root  (s1_root),
        .o_side  (s1_side_v)
    );
    assign s1_side = balas_pkg::t_front_side'(s1_side_v);

    // saturate the roots and form the speed sum
    always_ff @(posedge i_clk) begin
        logic [30:0] vu, vd;
        vu = balas_pkg::sat_u31(64'(s1_root[1]));
        vd = balas_pkg::sat_u31(64'(s1_root[2]));
        r_p1_sum         <= {1'b0, vu} + {1'b0, vd};
        r_p1_acc         <= s1_side.acc;
        r_p1_side.vu     <= vu;
        r_p1_side.hlen   <= balas_pkg::sat_u31(64'(s1_root[0]));
        r_p1_side.along  <= s1_side.along;
        r_p1_side.status <= s1_side.status;
    end

    balas_div #(
        .NUM_W  (TNUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(balas_pkg::t_tdiv_side))
    ) u_div_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p1_vld),
        .i_num   ({r_p1_sum, 16'h0000}),
        .i_den   (r_p1_acc),
        .i_side  (r_p1_side),
        .o_vld   (dt_vld),
        .o_quo   (dt_quo),
        .o_side  (dt_side_v)
    );
    assign dt_side = balas_pkg::t_tdiv_side'(dt_side_v);

    // clamp the flight time and set up the horizontal speed division
    assign n_p2_t = balas_pkg::sat_u31(64'(dt_quo));
    always_ff @(posedge i_clk) begin
        r_p2_num          <= {dt_side.hlen, 16'h0000};
        r_p2_side.vu      <= dt_side.vu;
        r_p2_side.t       <= n_p2_t;
        r_p2_side.along   <= dt_side.along;
        r_p2_side.status  <= dt_side.status;
        r_p2_side.tzero   <= (n_p2_t == '0);
        r_p2_side.hlen_nz <= (dt_side.hlen != '0);
    end

    balas_div #(
        .NUM_W  (VNUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(balas_pkg::t_vdiv_side))
    ) u_div_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p2_vld),
        .i_num   (r_p2_num),
        .i_den   (r_p2_side.t),
        .i_side  (r_p2_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side_v)
    );
    assign dv_side = balas_pkg::t_vdiv_side'(dv_side_v);

    // a zero flight time gives full speed unless there is no distance to cover
    always_comb begin
        if (dv_side.tzero) begin
            n_p3_vh = dv_side.hlen_nz ? balas_pkg::U31_MAX : '0;
        end else begin
            n_p3_vh = balas_pkg::sat_u31(64'(dv_quo));
        end
    end

    // hold speeds, square them and form time times up speed, then sum the squares and form the prediction
    always_ff @(posedge i_clk) begin
        r_p3_vh    <= n_p3_vh;
        r_p3_vu    <= dv_side.vu;
        r_p3_t     <= dv_side.t;
        r_p3_along <= dv_side.along;
        r_p3_st    <= dv_side.status;

        r_p4_vh2   <= r_p3_vh * r_p3_vh;
        r_p4_vu2   <= r_p3_vu * r_p3_vu;
        r_p4_tvu   <= r_p3_t * r_p3_vu;
        r_p4_vu    <= r_p3_vu;
        r_p4_along <= r_p3_along;
        r_p4_st    <= r_p3_st;

        r_p5_rad[0]      <= {2'b00, r_p4_vh2} + {2'b00, r_p4_vu2};
        r_p5_side.pred   <= balas_pkg::sat_s32($signed({18'd0, r_p4_tvu[61:16]})
                                               - 64'(r_p4_along));
        r_p5_side.vu     <= r_p4_vu;
        r_p5_side.status <= r_p4_st;
    end

    balas_sqrt #(
        .LANES  (1),
        .SIDE_W ($bits(balas_pkg::t_root_side))
    ) u_sqrt_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p5_vld),
        .i_rad   (r_p5_rad),
        .i_side  (r_p5_side),
        .o_vld   (s2_vld),
        .o_root  (s2_root),
        .o_side  (s2_side_v)
    );
    assign s2_side = balas_pkg::t_root_side'(s2_side_v);

    // advance valid bits of the glue stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_p5_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_p1_vld <= s1_vld;
            r_p2_vld <= dt_vld;
            r_p3_vld <= dv_vld;
            r_p4_vld <= r_p3_vld;
            r_p5_vld <= r_p4_vld;
            r_done   <= s2_vld;
        end
    end

    // drop the solution for linear and invalid beats
    always_ff @(posedge i_clk) begin
        r_status <= s2_side.status;
        if (s2_side.status == balas_pkg::ST_SOLVED) begin
            r_pred  <= s2_side.pred;
            r_speed <= balas_pkg::sat_u31(64'(s2_root[0]));
        end else begin
            r_pred  <= '0;
            r_speed <= '0;
        end
    end

    assign o_done        = r_done;
    assign o_prediction  = r_pred;
    assign o_start_speed = r_speed;
    assign o_status      = r_status;

    // launch speed covers at least the up speed
    a_speed_ge_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_vld && s2_side.status == balas_pkg::ST_SOLVED)
        |-> ({1'b0, s2_root[0]} >= {2'b00, s2_side.vu}))
        else $error("launch speed below up speed");

    // unsolved beats leave with zero payload
    a_unsolved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != balas_pkg::ST_SOLVED)
        |-> (o_prediction == '0 && o_start_speed == '0))
        else $error("unsolved beat carries a payload");

endmodule

// File: sv/balas_sqrt.sv
// Pipelined integer square root, one root bit per stage, several lanes in lockstep.
// Depends on balas_pkg for the radicand and root widths.
module balas_sqrt #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [balas_pkg::RAD_W-1:0]  i_rad [LANES],
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [balas_pkg::ROOT_W-1:0] o_root [LANES],
    output logic [SIDE_W-1:0]           o_side
);
    localparam int STEPS = balas_pkg::ROOT_W;
    localparam int RW    = balas_pkg::RAD_W;
    localparam int QW    = balas_pkg::ROOT_W;

    logic [STEPS-1:0]  r_vld;
    logic [SIDE_W-1:0] r_side [STEPS];
    logic [RW-1:0]     r_x    [STEPS][LANES];
    logic [QW+1:0]     r_rem  [STEPS][LANES];
    logic [QW-1:0]     r_root [STEPS][LANES];
    logic [RW-1:0]     n_x    [STEPS][LANES];
    logic [QW+1:0]     n_rem  [STEPS][LANES];
    logic [QW-1:0]     n_root [STEPS][LANES];

    // one trial subtraction per stage and lane
    always_comb begin
        logic [RW-1:0] src_x;
        logic [QW+1:0] src_rem;
        logic [QW-1:0] src_root;
        logic [QW+1:0] w_try;
        logic [QW+1:0] w_trial;
        for (int k = 0; k < STEPS; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    src_x    = i_rad[l];
                    src_rem  = '0;
                    src_root = '0;
                end else begin
                    src_x    = r_x[k-1][l];
                    src_rem  = r_rem[k-1][l];
                    src_root = r_root[k-1][l];
                end
                w_try   = {src_rem[QW-1:0], src_x[RW-1:RW-2]};
                w_trial = {src_root, 2'b01};
                n_x[k][l] = {src_x[RW-3:0], 2'b00};
                if (w_try >= w_trial) begin
                    n_rem[k][l]  = w_try - w_trial;
                    n_root[k][l] = {src_root[QW-2:0], 1'b1};
                end else begin
                    n_rem[k][l]  = w_try;
                    n_root[k][l] = {src_root[QW-2:0], 1'b0};
                end
            end
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STEPS-2:0], i_vld};
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_side[0] <= i_side;
        for (int k = 1; k < STEPS; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_side = r_side[STEPS-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_root[STEPS-1][l];
        end
    end

    // the remainder never exceeds twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (r_rem[STEPS-1][0] <= {1'b0, r_root[STEPS-1][0], 1'b0}))
        else $error("root remainder out of range");

endmodule

// File: sv/balas_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing beyond its own parameters.
module balas_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    localparam int STEPS = NUM_W;

    logic [STEPS-1:0]  r_vld;
    logic [SIDE_W-1:0] r_side [STEPS];
    logic [NUM_W-1:0]  r_num  [STEPS];
    logic [NUM_W-1:0]  r_quo  [STEPS];
    logic [DEN_W-1:0]  r_rem  [STEPS];
    logic [DEN_W-1:0]  r_den  [STEPS];
    logic [NUM_W-1:0]  n_num  [STEPS];
    logic [NUM_W-1:0]  n_quo  [STEPS];
    logic [DEN_W-1:0]  n_rem  [STEPS];

    // shift in one dividend bit and try the subtraction
    always_comb begin
        logic [NUM_W-1:0] src_num;
        logic [NUM_W-1:0] src_quo;
        logic [DEN_W-1:0] src_rem;
        logic [DEN_W-1:0] src_den;
        logic [DEN_W:0]   w_try;
        logic [DEN_W:0]   w_diff;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                src_num = i_num;
                src_quo = '0;
                src_rem = '0;
                src_den = i_den;
            end else begin
                src_num = r_num[k-1];
                src_quo = r_quo[k-1];
                src_rem = r_rem[k-1];
                src_den = r_den[k-1];
            end
            w_try    = {src_rem, src_num[NUM_W-1]};
            w_diff   = w_try - {1'b0, src_den};
            n_num[k] = {src_num[NUM_W-2:0], 1'b0};
            if (w_try >= {1'b0, src_den}) begin
                n_rem[k] = w_diff[DEN_W-1:0];
                n_quo[k] = {src_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = w_try[DEN_W-1:0];
                n_quo[k] = {src_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STEPS-2:0], i_vld};
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int k = 1; k < STEPS; k++) begin
            r_den[k]  <= r_den[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_quo  = r_quo[STEPS-1];
    assign o_side = r_side[STEPS-1];

    // a finished division leaves a remainder below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && r_den[STEPS-1] != '0) |-> (r_rem[STEPS-1] < r_den[STEPS-1]))
        else $error("divider remainder not below divisor");

endmodule

// File: sv/balas_front.sv
// Front end: offset, projection onto up, horizontal remainder and the root radicands.
// Depends on balas_pkg for status codes, side types and saturation helpers.
module balas_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic signed [31:0]        i_tip_x,
    input  logic signed [31:0]        i_tip_y,
    input  logic signed [31:0]        i_tip_z,
    input  logic signed [31:0]        i_aim_x,
    input  logic signed [31:0]        i_aim_y,
    input  logic signed [31:0]        i_aim_z,
    input  logic signed [17:0]        i_up_x,
    input  logic signed [17:0]        i_up_y,
    input  logic signed [17:0]        i_up_z,
    input  logic [30:0]               i_accel,
    input  logic [30:0]               i_height_max,
    input  logic [1:0]                i_mode,
    output logic                      o_vld,
    output logic [balas_pkg::RAD_W-1:0] o_rad [3],
    output balas_pkg::t_front_side    o_side
);
    logic [6:0] r_vld;

    // stage 1
    logic signed [31:0]  r1_rel [3];
    logic signed [17:0]  r1_up  [3];
    logic [30:0]         r1_acc, r1_hmax;
    balas_pkg::t_status  r1_st, n1_st;
    // stage 2
    logic signed [49:0]  r2_prod [3];
    logic signed [31:0]  r2_rel  [3];
    logic signed [17:0]  r2_up   [3];
    logic [30:0]         r2_acc, r2_hmax;
    balas_pkg::t_status  r2_st;
    // stage 3
    logic signed [31:0]  r3_along;
    logic signed [31:0]  r3_rel [3];
    logic signed [17:0]  r3_up  [3];
    logic [30:0]         r3_acc, r3_hmax;
    balas_pkg::t_status  r3_st;
    logic signed [51:0]  n3_dot;
    // stage 4
    logic signed [49:0]  r4_cprod [3];
    logic signed [31:0]  r4_rel   [3];
    logic signed [31:0]  r4_along;
    logic [30:0]         r4_acc, r4_h, r4_d;
    balas_pkg::t_status  r4_st;
    logic signed [32:0]  n4_diff;
    logic [30:0]         n4_h, n4_d;
    // stage 5
    logic signed [31:0]  r5_hc [3];
    logic [61:0]         r5_hacc, r5_dacc;
    logic signed [31:0]  r5_along;
    logic [30:0]         r5_acc;
    balas_pkg::t_status  r5_st;
    logic signed [31:0]  n5_hc [3];
    // stage 6
    logic signed [63:0]  r6_sq [3];
    logic [63:0]         r6_radu, r6_radd;
    logic signed [31:0]  r6_along;
    logic [30:0]         r6_acc;
    balas_pkg::t_status  r6_st;
    // stage 7
    logic [63:0]         r7_sum, r7_radu, r7_radd;
    logic signed [31:0]  r7_along;
    logic [30:0]         r7_acc;
    balas_pkg::t_status  r7_st;

    // classify the beat
    always_comb begin
        if (i_mode == balas_pkg::MODE_BALLISTIC) begin
            n1_st = (i_accel == '0 || i_height_max == '0) ?
                    balas_pkg::ST_INVALID : balas_pkg::ST_SOLVED;
        end else if (i_mode == balas_pkg::MODE_LINEAR) begin
            n1_st = balas_pkg::ST_LINEAR;
        end else begin
            n1_st = balas_pkg::ST_INVALID;
        end
    end

    // sum of the up projections
    assign n3_dot = 52'(r2_prod[0]) + 52'(r2_prod[1]) + 52'(r2_prod[2]);

    // raise the apex to the target and take the drop from the apex
    always_comb begin
        n4_diff = $signed({2'b00, r3_hmax}) - $signed({r3_along[31], r3_along});
        if (n4_diff[32]) begin
            n4_h = r3_along[30:0];
            n4_d = '0;
        end else begin
            n4_h = r3_hmax;
            n4_d = n4_diff[31] ? balas_pkg::U31_MAX : n4_diff[30:0];
        end
    end

    // horizontal remainder of each component
    always_comb begin
        logic signed [31:0] corr;
        for (int i = 0; i < 3; i++) begin
            corr     = balas_pkg::sat_s32(64'(r4_cprod[i] >>> 16));
            n5_hc[i] = balas_pkg::sat_s32(64'(r4_rel[i]) - 64'(corr));
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r1_rel[0] <= balas_pkg::sat_s32(64'(i_aim_x) - 64'(i_tip_x));
        r1_rel[1] <= balas_pkg::sat_s32(64'(i_aim_y) - 64'(i_tip_y));
        r1_rel[2] <= balas_pkg::sat_s32(64'(i_aim_z) - 64'(i_tip_z));
        r1_up[0]  <= i_up_x;
        r1_up[1]  <= i_up_y;
        r1_up[2]  <= i_up_z;
        r1_acc    <= i_accel;
        r1_hmax   <= i_height_max;
        r1_st     <= n1_st;

        for (int i = 0; i < 3; i++) begin
            r2_prod[i]  <= r1_up[i] * r1_rel[i];
            r2_rel[i]   <= r1_rel[i];
            r2_up[i]    <= r1_up[i];
            r3_rel[i]   <= r2_rel[i];
            r3_up[i]    <= r2_up[i];
            r4_cprod[i] <= r3_up[i] * r3_along;
            r4_rel[i]   <= r3_rel[i];
            r5_hc[i]    <= n5_hc[i];
            r6_sq[i]    <= r5_hc[i] * r5_hc[i];
        end
        r2_acc  <= r1_acc;
        r2_hmax <= r1_hmax;
        r2_st   <= r1_st;

        r3_along <= balas_pkg::sat_s32(64'(n3_dot >>> 16));
        r3_acc   <= r2_acc;
        r3_hmax  <= r2_hmax;
        r3_st    <= r2_st;

        r4_h     <= n4_h;
        r4_d     <= n4_d;
        r4_along <= r3_along;
        r4_acc   <= r3_acc;
        r4_st    <= r3_st;

        r5_hacc  <= r4_h * r4_acc;
        r5_dacc  <= r4_d * r4_acc;
        r5_along <= r4_along;
        r5_acc   <= r4_acc;
        r5_st    <= r4_st;

        r6_radu  <= {1'b0, r5_hacc, 1'b0};
        r6_radd  <= {1'b0, r5_dacc, 1'b0};
        r6_along <= r5_along;
        r6_acc   <= r5_acc;
        r6_st    <= r5_st;

        r7_sum   <= $unsigned(r6_sq[0]) + $unsigned(r6_sq[1]) + $unsigned(r6_sq[2]);
        r7_radu  <= r6_radu;
        r7_radd  <= r6_radd;
        r7_along <= r6_along;
        r7_acc   <= r6_acc;
        r7_st    <= r6_st;
    end

    assign o_vld        = r_vld[6];
    assign o_rad[0]     = r7_sum;
    assign o_rad[1]     = r7_radu;
    assign o_rad[2]     = r7_radd;
    assign o_side.along  = r7_along;
    assign o_side.acc    = r7_acc;
    assign o_side.status = r7_st;

endmodule
